FILE: sv/lphs_pkg.sv
// Shared widths and result codes for the linear-probe hash set insert block.
package lphs_pkg;

    localparam int KEY_W       = 64;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 12;
    localparam int COUNT_OUT_W = 13;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW     = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

endpackage

FILE: sv/linear_probe_hash_set_insert.sv
// Hash set insert with open addressing and linear probing over one key memory.
//
// Each word on i_key is a 64-bit key that is already a hash; a key of zero is
// stored as one, since zero marks an empty slot. Assert start while busy is
// low to hand in a word. The probe begins at the slot given by the key's low
// SLOT_BITS bits and steps one slot at a time, wrapping at the end. Exactly
// one result comes back per word: o_valid is high for a single cycle with
// o_status (new, present or full), o_slot_index and o_entry_count. The
// receiver cannot stall, so capture the result in that cycle. An insert
// probes n slots (1 <= n <= 2^SLOT_BITS) and keeps busy high from the
// accepting edge until its result; the result strobe appears in the cycle
// busy drops and a new word may be accepted in that same cycle, so a word
// is not taken before the last one is through. Each probe is one read of
// the key memory through its registered read port. After reset the block
// clears the memory, one slot per cycle, with busy held high. When every
// slot was visited without a match or an empty slot, status is full, the
// slot index is zero and the count repeats.
module linear_probe_hash_set_insert #(
    parameter int SLOT_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [lphs_pkg::KEY_W-1:0]         i_key,
    output logic                               busy,
    output logic                               o_valid,
    output logic [lphs_pkg::STATUS_W-1:0]      o_status,
    output logic [lphs_pkg::SLOT_OUT_W-1:0]    o_slot_index,
    output logic [lphs_pkg::COUNT_OUT_W-1:0]   o_entry_count
);

    localparam int SLOT_CNT = 1 << SLOT_BITS;
    localparam int CNT_W    = SLOT_BITS + 1;

    // One-hot sequencer states
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,   // post-reset sweep writing zero to every slot
        S_IDLE  = 4'b0010,   // waiting for start
        S_CHECK = 4'b0100,   // read data for r_pos is in r_rd_data
        S_SPARE = 4'b1000    // unused, recovers to idle
    } t_state;

    t_state                         r_state, n_state;
    logic [lphs_pkg::KEY_W-1:0]     r_key, n_key;
    logic [SLOT_BITS-1:0]           r_pos, n_pos;
    logic [SLOT_BITS-1:0]           r_visited, n_visited;
    logic [CNT_W-1:0]               r_count, n_count;
    logic                           r_valid, n_valid;
    lphs_pkg::t_status              r_status, n_status;
    logic [lphs_pkg::SLOT_OUT_W-1:0]  r_slot, n_slot;
    logic [lphs_pkg::COUNT_OUT_W-1:0] r_entry, n_entry;

    // Key memory: one write port, one registered read port
    logic [lphs_pkg::KEY_W-1:0]     mem [SLOT_CNT];
    logic [lphs_pkg::KEY_W-1:0]     r_rd_data;
    logic                           mem_rd_en;
    logic [SLOT_BITS-1:0]           mem_rd_addr;
    logic                           mem_we;
    logic [SLOT_BITS-1:0]           mem_wr_addr;
    logic [lphs_pkg::KEY_W-1:0]     mem_wr_data;

    logic [lphs_pkg::KEY_W-1:0]     key_in;
    logic                           hit_empty;
    logic                           hit_equal;

    // Zero is reserved for empty slots
    assign key_in    = (i_key == '0) ? lphs_pkg::KEY_W'(1) : i_key;
    assign hit_empty = (r_rd_data == '0);
    assign hit_equal = (r_rd_data == r_key);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= mem[mem_rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_pos       = r_pos;
        n_visited   = r_visited;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_slot      = r_slot;
        n_entry     = r_entry;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_pos;
        mem_we      = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_pos  = r_pos + 1'b1;
                if (r_pos == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_key       = key_in;
                    n_pos       = key_in[SLOT_BITS-1:0];
                    n_visited   = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = key_in[SLOT_BITS-1:0];
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (hit_empty) begin
                    mem_we      = 1'b1;
                    mem_wr_data = r_key;
                    n_count     = r_count + 1'b1;
                    n_valid     = 1'b1;
                    n_status    = lphs_pkg::ST_NEW;
                    n_slot      = lphs_pkg::SLOT_OUT_W'(r_pos);
                    n_entry     = lphs_pkg::COUNT_OUT_W'(n_count);
                    n_state     = S_IDLE;
                end else if (hit_equal) begin
                    n_valid     = 1'b1;
                    n_status    = lphs_pkg::ST_PRESENT;
                    n_slot      = lphs_pkg::SLOT_OUT_W'(r_pos);
                    n_entry     = lphs_pkg::COUNT_OUT_W'(r_count);
                    n_state     = S_IDLE;
                end else if (r_visited == '1) begin
                    // wrapped all the way around
                    n_valid     = 1'b1;
                    n_status    = lphs_pkg::ST_FULL;
                    n_slot      = '0;
                    n_entry     = lphs_pkg::COUNT_OUT_W'(r_count);
                    n_state     = S_IDLE;
                end else begin
                    n_pos       = r_pos + 1'b1;
                    n_visited   = r_visited + 1'b1;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_pos + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_pos     <= '0;
            r_visited <= '0;
            r_count   <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_visited <= n_visited;
            r_count   <= n_count;
            r_valid   <= n_valid;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_entry  <= n_entry;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot;
    assign o_entry_count = r_entry;

endmodule
